@@ rtl/soc_pkg.sv @@
// shared types for the segment obstacle collision checker
package soc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_LEN,
        ST_CHK,
        ST_RT_MUL,
        ST_RT_CMP,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_POINT,
        ST_RD,
        ST_EX,
        ST_EY,
        ST_ER,
        ST_CMP,
        ST_OUT
    } state_t;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic REG_COUNT   = 1'b0;
    localparam logic REG_INFLATE = 1'b1;

    localparam int COORD_W  = 24;
    localparam int RAD_W    = 20;
    localparam int DELTA_W  = 25;
    localparam int SQ_IN_W  = 26;
    localparam int SQ_OUT_W = 51;

endpackage

@@ rtl/soc_sq.sv @@
// shared squaring unit with registered result
module soc_sq (
    input  logic                               clk,
    input  logic signed [soc_pkg::SQ_IN_W-1:0] a,
    output logic        [soc_pkg::SQ_OUT_W-1:0] sq
);
    import soc_pkg::*;

    logic [SQ_IN_W-1:0]     mag;
    logic [2*SQ_IN_W-1:0]   prod;

    assign mag  = a[SQ_IN_W-1] ? (~a + 1'b1) : a;
    assign prod = mag * mag;

    always_ff @(posedge clk)
    begin
        sq <= prod[SQ_OUT_W-1:0];
    end
endmodule

@@ rtl/soc_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module soc_div #(
    parameter int DW = 25,
    parameter int VW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);
    import soc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW+1:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, divisor})
            begin
                rem_next = (VW+1)'(trial - {2'b00, divisor});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[VW-1:0];
endmodule

@@ rtl/segment_obstacle_collision_check.sv @@
// segment versus circular obstacle table collision checker, top level
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | opcode, start/end xy, slot, center xy, radius
//  out     | out_valid / out_ready | collision, too_long
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// a load answers in the cycle after acceptance; a query computes the squared length, then
// the root bit by bit (ST_RT_MUL, ST_RT_CMP), then the two divisions, then per sample point
// ST_POINT plus ST_RD, ST_EX, ST_EY, ST_ER and ST_CMP per obstacle, through the one shared
// squaring unit and table read port
// one transaction at a time: in_ready is low from acceptance until the result is taken
// reset clears control and the configuration registers; the obstacle table is not cleared
module segment_obstacle_collision_check #(
    parameter int MAX_OBSTACLES = 64,
    parameter int MAX_STEPS     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [23:0] start_x,
    input  logic [23:0] start_y,
    input  logic [23:0] end_x,
    input  logic [23:0] end_y,
    input  logic [5:0]  slot,
    input  logic [23:0] center_x,
    input  logic [23:0] center_y,
    input  logic [19:0] radius,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        collision,
    output logic        too_long,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);
    import soc_pkg::*;

    localparam int OBS_W  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W  = $clog2(MAX_OBSTACLES + 1);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int L_W    = SQ_OUT_W - 14;
    localparam int ENT_W  = 2 * COORD_W + RAD_W;
    localparam logic [L_W-1:0] LIM = L_W'((MAX_STEPS + 1) * (MAX_STEPS + 1));

    state_t state_reg, state_next;

    logic [6:0]              count_cfg_reg;
    logic [RAD_W-1:0]        inflate_reg;
    logic [ENT_W-1:0]        mem [MAX_OBSTACLES];
    logic [ENT_W-1:0]        rd_data_reg;

    logic signed [DELTA_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [DELTA_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DELTA_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [SQ_OUT_W:0]         acc_reg, acc_next;
    logic [STEP_W-1:0]         root_reg, root_next;
    logic [STEP_W-1:0]         bit_reg, bit_next;
    logic [STEP_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next, k_reg, k_next;
    logic [DELTA_W-1:0]        qdx_reg, qdx_next, qdy_reg, qdy_next;
    logic [STEP_W-1:0]         rdx_reg, rdx_next, rdy_reg, rdy_next;
    logic [DELTA_W-1:0]        qx_reg, qx_next, qy_reg, qy_next;
    logic [STEP_W:0]           rx_reg, rx_next, ry_reg, ry_next;
    logic                      coll_reg, coll_next, long_reg, long_next;

    logic signed [SQ_IN_W-1:0] sq_a;
    logic [SQ_OUT_W-1:0]       sq_out;
    logic                      div_start;
    logic [DELTA_W-1:0]        div_a;
    logic                      div_done;
    logic [DELTA_W-1:0]        div_q;
    logic [STEP_W-1:0]         div_r;

    logic [L_W-1:0]            len_l;
    logic [STEP_W-1:0]         trial;
    logic [31:0]               slot_ext;
    logic [31:0]               count_ext;
    logic signed [SQ_IN_W-1:0] cx, cy;
    logic [RAD_W:0]            rsum;
    logic [STEP_W:0]           rx_sum, ry_sum;

    soc_sq u_sq (
        .clk (clk),
        .a   (sq_a),
        .sq  (sq_out)
    );

    soc_div #(
        .DW (DELTA_W),
        .VW (STEP_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (root_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign len_l     = acc_reg[SQ_OUT_W-1:14];
    assign trial     = root_reg | (STEP_W'(1) << bit_reg);
    assign slot_ext  = 32'(slot);
    assign count_ext = 32'(count_cfg_reg);
    assign cx        = SQ_IN_W'($signed(rd_data_reg[ENT_W-1 -: COORD_W]));
    assign cy        = SQ_IN_W'($signed(rd_data_reg[ENT_W-COORD_W-1 -: COORD_W]));
    assign rsum      = {1'b0, rd_data_reg[RAD_W-1:0]} + {1'b0, inflate_reg};
    assign rx_sum    = rx_reg + {1'b0, rdx_reg};
    assign ry_sum    = ry_reg + {1'b0, rdy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= '0;
            inflate_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COUNT:   count_cfg_reg <= cfg_data[6:0];
                REG_INFLATE: inflate_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // obstacle table: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && opcode == OP_LOAD
            && slot_ext < 32'(MAX_OBSTACLES))
        begin
            mem[slot_ext[OBS_W-1:0]] <= {center_x, center_y, radius};
        end
        rd_data_reg <= mem[k_reg[OBS_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        sx_next = sx_reg;   sy_next = sy_reg;
        dx_next = dx_reg;   dy_next = dy_reg;
        px_next = px_reg;   py_next = py_reg;
        acc_next = acc_reg;
        root_next = root_reg;
        bit_next = bit_reg;
        i_next = i_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        qdx_next = qdx_reg; qdy_next = qdy_reg;
        rdx_next = rdx_reg; rdy_next = rdy_reg;
        qx_next = qx_reg;   qy_next = qy_reg;
        rx_next = rx_reg;   ry_next = ry_reg;
        coll_next = coll_reg;
        long_next = long_reg;
        sq_a = '0;
        div_start = 1'b0;
        div_a = dx_reg[DELTA_W-1] ? DELTA_W'(-dx_reg) : dx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    coll_next = 1'b0;
                    long_next = 1'b0;
                    if (opcode == OP_LOAD)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sx_next = DELTA_W'($signed(start_x));
                        sy_next = DELTA_W'($signed(start_y));
                        dx_next = DELTA_W'($signed(end_x)) - DELTA_W'($signed(start_x));
                        dy_next = DELTA_W'($signed(end_y)) - DELTA_W'($signed(start_y));
                        cnt_next = (count_ext > 32'(MAX_OBSTACLES)) ?
                                   CNT_W'(MAX_OBSTACLES) : CNT_W'(count_cfg_reg);
                        state_next = ST_SQ_DX;
                    end
                end
            end
            ST_SQ_DX:
            begin
                sq_a = SQ_IN_W'(dx_reg);
                state_next = ST_SQ_DY;
            end
            ST_SQ_DY:
            begin
                sq_a = SQ_IN_W'(dy_reg);
                acc_next = {1'b0, sq_out};
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                acc_next = acc_reg + {1'b0, sq_out};
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                root_next = '0;
                bit_next = STEP_W'(STEP_W - 1);
                if (len_l >= LIM)
                begin
                    coll_next = 1'b1;
                    long_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RT_MUL;
                end
            end
            ST_RT_MUL:
            begin
                sq_a = SQ_IN_W'(trial);
                state_next = ST_RT_CMP;
            end
            ST_RT_CMP:
            begin
                if (sq_out <= SQ_OUT_W'(len_l))
                begin
                    root_next = trial;
                end
                if (bit_reg == '0)
                begin
                    qdx_next = '0; qdy_next = '0;
                    rdx_next = '0; rdy_next = '0;
                    // a zero-length walk tests only the start point
                    if (root_next == '0)
                    begin
                        state_next = ST_POINT;
                    end
                    else
                    begin
                        state_next = ST_DIVX_GO;
                    end
                    i_next = '0;
                    qx_next = '0; qy_next = '0;
                    rx_next = '0; ry_next = '0;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                    state_next = ST_RT_MUL;
                end
            end
            ST_DIVX_GO:
            begin
                div_start = 1'b1;
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                begin
                    qdx_next = div_q;
                    rdx_next = div_r;
                    state_next = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO:
            begin
                div_a = dy_reg[DELTA_W-1] ? DELTA_W'(-dy_reg) : dy_reg;
                div_start = 1'b1;
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                begin
                    qdy_next = div_q;
                    rdy_next = div_r;
                    state_next = ST_POINT;
                end
            end
            ST_POINT:
            begin
                // truncation toward zero: apply the sign to the magnitude quotient
                px_next = dx_reg[DELTA_W-1] ? sx_reg - qx_reg : sx_reg + qx_reg;
                py_next = dy_reg[DELTA_W-1] ? sy_reg - qy_reg : sy_reg + qy_reg;
                k_next = '0;
                state_next = (cnt_reg == '0) ? ST_OUT : ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                sq_a = SQ_IN_W'(px_reg) - cx;
                state_next = ST_EY;
            end
            ST_EY:
            begin
                sq_a = SQ_IN_W'(py_reg) - cy;
                acc_next = {1'b0, sq_out};
                state_next = ST_ER;
            end
            ST_ER:
            begin
                sq_a = SQ_IN_W'(rsum);
                acc_next = acc_reg + {1'b0, sq_out};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (acc_reg < {1'b0, sq_out})
                begin
                    coll_next = 1'b1;
                    state_next = ST_OUT;
                end
                else if (k_reg + 1'b1 == cnt_reg)
                begin
                    if (i_reg == root_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        if (rx_sum >= {1'b0, root_reg})
                        begin
                            rx_next = rx_sum - {1'b0, root_reg};
                            qx_next = qx_reg + qdx_reg + 1'b1;
                        end
                        else
                        begin
                            rx_next = rx_sum;
                            qx_next = qx_reg + qdx_reg;
                        end
                        if (ry_sum >= {1'b0, root_reg})
                        begin
                            ry_next = ry_sum - {1'b0, root_reg};
                            qy_next = qy_reg + qdy_reg + 1'b1;
                        end
                        else
                        begin
                            ry_next = ry_sum;
                            qy_next = qy_reg + qdy_reg;
                        end
                        state_next = ST_POINT;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            coll_reg  <= 1'b0;
            long_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            coll_reg  <= coll_next;
            long_reg  <= long_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg   <= sx_next;   sy_reg   <= sy_next;
        dx_reg   <= dx_next;   dy_reg   <= dy_next;
        px_reg   <= px_next;   py_reg   <= py_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        i_reg    <= i_next;
        cnt_reg  <= cnt_next;
        qdx_reg  <= qdx_next;  qdy_reg  <= qdy_next;
        rdx_reg  <= rdx_next;  rdy_reg  <= rdy_next;
        qx_reg   <= qx_next;   qy_reg   <= qy_next;
        rx_reg   <= rx_next;   ry_reg   <= ry_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign collision = coll_reg;
    assign too_long  = long_reg;
endmodule

@@ rtl/soc_checker.sv @@
// port-level checks for the collision checker, bound to the top level
module soc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic opcode,
    input logic out_valid,
    input logic out_ready,
    input logic collision,
    input logic too_long
);
    import soc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(collision) && $stable(too_long))
        else $error("result changed while stalled");

    a_long_hits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_long |-> collision)
        else $error("too_long without collision");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result waits");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_LOAD |=> out_valid && !collision && !too_long)
        else $error("load result wrong");

    a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("not ready after result taken");
endmodule

bind segment_obstacle_collision_check soc_checker u_soc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .collision (collision),
    .too_long  (too_long)
);
